// ===== hw/rtl/msas_pkg.sv =====
// ----------------------------------------------------------------------------
// msas_pkg
// Shared constants, word types and control structs of the multiplexed
// sensor averaging scaler.
// ----------------------------------------------------------------------------
package msas_pkg;

    // Block sizing
    localparam int CHANNELS    = 16;
    localparam int WINDOW      = 5;
    localparam int SAMPLE_BITS = 12;

    // Fixed widths of the external word fields
    localparam int FIELD_W   = 12;
    localparam int CHAN_W    = 4;
    localparam int LEVEL_W   = 8;
    localparam int ORDER_W   = 64;

    // Derived internal widths
    localparam int VAL_W      = SAMPLE_BITS;
    localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW);
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int PTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RING_DEPTH = CHANNELS * WINDOW;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int DIVN_W     = VAL_W + LEVEL_W;
    localparam int CNT_W      = $clog2(VAL_W + 1);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX           = 8'd255;
    localparam logic [ORDER_W-1:0] CHANNEL_ORDER_RESET = 64'hFEDC_BA98_7654_3210;

    // Word kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CAL    = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] sample;
        logic [CHAN_W-1:0]  cal_channel;
        logic [FIELD_W-1:0] cal_up;
        logic [FIELD_W-1:0] cal_down;
    } req_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic [FIELD_W-1:0] averaged;
        logic [LEVEL_W-1:0] level;
        logic [CHAN_W-1:0]  mux_select;
    } rsp_word_t;

    // Per-channel record held in the channel RAM
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [PTR_W-1:0]  ptr;
        logic [FILL_W-1:0] fill;
        logic [VAL_W-1:0]  lo;
        logic [VAL_W-1:0]  hi;
        logic              inv;
    } chan_state_t;

    localparam int CHAN_STATE_W = $bits(chan_state_t);

    // Serial divider request / response
    typedef struct packed {
        logic              start;
        logic [VAL_W-1:0]  rem_init;
        logic [DIVN_W-1:0] dividend;
        logic [VAL_W-1:0]  divisor;
        logic [CNT_W-1:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [VAL_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_RD,
        ST_SMP_RD,
        ST_RING,
        ST_AVG_DIV,
        ST_CLAMP,
        ST_SCALE,
        ST_LVL_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/msas_ram.sv =====
// ----------------------------------------------------------------------------
// msas_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module msas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/msas_div.sv =====
// ----------------------------------------------------------------------------
// msas_div
// Restoring serial divider, one quotient bit per cycle. The caller passes
// the upper dividend bits as the starting remainder (must be below the
// divisor) and the remaining bits left-aligned, with the step count.
// ----------------------------------------------------------------------------
module msas_div (
    input  logic                clk,
    input  logic                rst_n,
    input  msas_pkg::div_req_t  div_req,
    output msas_pkg::div_rsp_t  div_rsp
);

    import msas_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [DIVN_W-1:0] num_reg;
    logic [VAL_W-1:0]  quo_reg;
    logic [VAL_W-1:0]  dvs_reg;

    logic [VAL_W:0]    trial;
    logic              ge;
    logic [VAL_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[DIVN_W-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? VAL_W'(trial - {1'b0, dvs_reg}) : VAL_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= div_req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            rem_reg <= div_req.rem_init;
            num_reg <= div_req.dividend;
            dvs_reg <= div_req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[DIVN_W-2:0], 1'b0};
            quo_reg <= {quo_reg[VAL_W-2:0], ge};
        end
    end

    assign div_rsp.busy     = busy_reg;
    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/muxed_sensor_average_scaler.sv =====
// ----------------------------------------------------------------------------
// muxed_sensor_average_scaler
// A sample word passes channel read, ring update, average divide, clamp,
// scale and level divide; a degenerate calibration range skips the last
// two. The shared serial divider gives a 12-bit average, then an 8-bit
// level. Words are taken only when idle; calibration words give no result.
// Reset: rst_n clears index and valid bits, reloads mux order; no RAM sweep.
// ----------------------------------------------------------------------------
module muxed_sensor_average_scaler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  msas_pkg::req_word_t                 req_word,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output msas_pkg::rsp_word_t                 rsp_word,
    input  logic                                cfg_wr_en,
    input  logic [msas_pkg::ORDER_W-1:0]        cfg_wr_data
);

    import msas_pkg::*;

    // ------------------------------------------------------------------
    // State and payload registers
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [CHAN_W-1:0]     cur_ch_reg;
    logic [CHANNELS-1:0]   chan_valid_reg;   // entry written since reset
    logic [ORDER_W-1:0]    channel_order_reg;
    logic                  rsp_valid_reg;
    rsp_word_t             rsp_word_reg;

    req_word_t             item_reg;
    chan_state_t           cs_reg;
    logic [VAL_W-1:0]      avg_reg;
    logic [VAL_W-1:0]      d_reg;            // clamped - lo
    logic [VAL_W-1:0]      r_reg;            // hi - lo
    logic [LEVEL_W-1:0]    level_reg;

    // ------------------------------------------------------------------
    // Memory ports and divider
    // ------------------------------------------------------------------
    logic                    chan_rd_en;
    logic [CH_AW-1:0]        chan_rd_addr;
    logic [CHAN_STATE_W-1:0] chan_rdata;
    logic                    chan_we;
    logic [CH_AW-1:0]        chan_wr_addr;
    chan_state_t             chan_wr_data;

    logic                    ring_rd_en;
    logic                    ring_we;
    logic [RING_AW-1:0]      ring_addr;
    logic [VAL_W-1:0]        ring_rdata;

    div_req_t                div_req;
    div_rsp_t                div_rsp;

    logic                    req_fire;
    logic                    rsp_load;

    msas_ram #(
        .WIDTH (CHAN_STATE_W),
        .DEPTH (CHANNELS)
    ) u_chan_ram (
        .clk     (clk),
        .we      (chan_we),
        .wr_addr (chan_wr_addr),
        .wr_data (chan_wr_data),
        .rd_en   (chan_rd_en),
        .rd_addr (chan_rd_addr),
        .rd_data (chan_rdata)
    );

    msas_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk     (clk),
        .we      (ring_we),
        .wr_addr (ring_addr),
        .wr_data (VAL_W'(item_reg.sample)),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_addr),
        .rd_data (ring_rdata)
    );

    msas_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic              cal_in_range;
    logic [CH_AW-1:0]  cal_addr;
    logic [CH_AW-1:0]  cur_addr;
    chan_state_t       cs_rd;          // RAM word, zero if never written
    chan_state_t       cs_cal;         // record with new calibration
    chan_state_t       cs_upd;         // record after adding the sample
    logic [VAL_W-1:0]  raw;
    logic [VAL_W-1:0]  cal_up_v;
    logic [VAL_W-1:0]  cal_down_v;
    logic [VAL_W-1:0]  ring_old;
    logic [SUM_W-1:0]  sum_new;
    logic [VAL_W-1:0]  clamp_lo;
    logic [VAL_W-1:0]  clamped;
    logic [DIVN_W-1:0] scale_num;
    logic [CHAN_W-1:0] ch_next;
    logic [PTR_W-1:0]  ring_ptr;

    always_comb
    begin
        cal_in_range = (32'(req_word.cal_channel) < CHANNELS);
        cal_addr     = item_reg.cal_channel[CH_AW-1:0];
        cur_addr     = cur_ch_reg[CH_AW-1:0];

        // Entries not yet written read as their reset value
        if (state_reg == ST_CAL_RD)
        begin
            cs_rd = chan_valid_reg[cal_addr] ? chan_state_t'(chan_rdata) : '0;
        end
        else
        begin
            cs_rd = chan_valid_reg[cur_addr] ? chan_state_t'(chan_rdata) : '0;
        end

        // Calibration: low/high ordered, invert assigned from the sign
        cal_up_v   = VAL_W'(item_reg.cal_up);
        cal_down_v = VAL_W'(item_reg.cal_down);
        cs_cal     = cs_rd;
        cs_cal.lo  = (cal_up_v < cal_down_v) ? cal_up_v : cal_down_v;
        cs_cal.hi  = (cal_up_v > cal_down_v) ? cal_up_v : cal_down_v;
        cs_cal.inv = (cal_up_v > cal_down_v);

        // Ring slot is only live once the window has filled
        raw      = VAL_W'(item_reg.sample);
        ring_old = (cs_reg.fill == FILL_W'(WINDOW)) ? ring_rdata : '0;
        sum_new  = cs_reg.sum - SUM_W'(ring_old) + SUM_W'(raw);

        cs_upd     = cs_reg;
        cs_upd.sum = sum_new;
        cs_upd.ptr = (cs_reg.ptr == PTR_W'(WINDOW - 1)) ? '0 : cs_reg.ptr + PTR_W'(1);
        if (cs_reg.fill != FILL_W'(WINDOW))
        begin
            cs_upd.fill = cs_reg.fill + FILL_W'(1);
        end

        ring_ptr  = (state_reg == ST_SMP_RD) ? cs_rd.ptr : cs_reg.ptr;
        ring_addr = RING_AW'(32'(cur_ch_reg) * WINDOW + 32'(ring_ptr));

        // Clamp: raise to low first, then lower to high
        clamp_lo = (avg_reg < cs_reg.lo) ? cs_reg.lo : avg_reg;
        clamped  = (clamp_lo > cs_reg.hi) ? cs_reg.hi : clamp_lo;

        // d * 255 as a shift and subtract
        scale_num = {d_reg, {LEVEL_W{1'b0}}} - DIVN_W'(d_reg);

        ch_next = (cur_ch_reg == CHAN_W'(CHANNELS - 1)) ? '0 : cur_ch_reg + CHAN_W'(1);
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_word.kind == KIND_CAL)
                    begin
                        if (cal_in_range)
                        begin
                            state_next = ST_CAL_RD;
                        end
                    end
                    else
                    begin
                        state_next = ST_SMP_RD;
                    end
                end
            end
            ST_CAL_RD:  state_next = ST_IDLE;
            ST_SMP_RD:  state_next = ST_RING;
            ST_RING:    state_next = ST_AVG_DIV;
            ST_AVG_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:   state_next = (cs_reg.hi > cs_reg.lo) ? ST_SCALE : ST_DONE;
            ST_SCALE:   state_next = ST_LVL_DIV;
            ST_LVL_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        req_ready    = 1'b0;
        chan_rd_en   = 1'b0;
        chan_rd_addr = cur_addr;
        chan_we      = 1'b0;
        chan_wr_addr = cur_addr;
        chan_wr_data = cs_upd;
        ring_rd_en   = 1'b0;
        ring_we      = 1'b0;
        rsp_load     = 1'b0;

        div_req.start    = 1'b0;
        div_req.rem_init = VAL_W'(sum_new >> VAL_W);
        div_req.dividend = {sum_new[VAL_W-1:0], {LEVEL_W{1'b0}}};
        div_req.divisor  = VAL_W'(cs_upd.fill);
        div_req.steps    = CNT_W'(VAL_W);

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                chan_rd_en = req_valid;
                if (req_word.kind == KIND_CAL)
                begin
                    chan_rd_addr = req_word.cal_channel[CH_AW-1:0];
                end
            end
            ST_CAL_RD:
            begin
                chan_we      = 1'b1;
                chan_wr_addr = cal_addr;
                chan_wr_data = cs_cal;
            end
            ST_SMP_RD:
            begin
                ring_rd_en = 1'b1;
            end
            ST_RING:
            begin
                ring_we       = 1'b1;
                chan_we       = 1'b1;
                div_req.start = 1'b1;
            end
            ST_SCALE:
            begin
                div_req.start    = 1'b1;
                div_req.rem_init = scale_num[DIVN_W-1:LEVEL_W];
                div_req.dividend = {scale_num[LEVEL_W-1:0], {VAL_W{1'b0}}};
                div_req.divisor  = r_reg;
                div_req.steps    = CNT_W'(LEVEL_W);
            end
            ST_DONE:
            begin
                rsp_load = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
            end
        endcase
    end

    assign req_fire = req_valid && req_ready;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cur_ch_reg        <= '0;
            chan_valid_reg    <= '0;
            channel_order_reg <= CHANNEL_ORDER_RESET;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                channel_order_reg <= cfg_wr_data;
            end
            if (chan_we)
            begin
                chan_valid_reg[chan_wr_addr] <= 1'b1;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
                cur_ch_reg    <= ch_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg <= req_word;
        end
        unique case (state_reg)
            ST_SMP_RD:  cs_reg <= cs_rd;
            ST_RING:    cs_reg <= cs_upd;
            ST_AVG_DIV:
            begin
                if (div_rsp.done)
                begin
                    avg_reg <= div_rsp.quotient;
                end
            end
            ST_CLAMP:
            begin
                d_reg     <= clamped - cs_reg.lo;
                r_reg     <= cs_reg.hi - cs_reg.lo;
                // degenerate range scales to zero
                level_reg <= cs_reg.inv ? LEVEL_MAX : '0;
            end
            ST_LVL_DIV:
            begin
                if (div_rsp.done)
                begin
                    level_reg <= cs_reg.inv ? LEVEL_MAX - div_rsp.quotient[LEVEL_W-1:0]
                                            : div_rsp.quotient[LEVEL_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        if (rsp_load)
        begin
            rsp_word_reg.channel    <= cur_ch_reg;
            rsp_word_reg.averaged   <= FIELD_W'(avg_reg);
            rsp_word_reg.level      <= level_reg;
            rsp_word_reg.mux_select <= channel_order_reg[{ch_next, 2'b00} +: CHAN_W];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

`ifndef SYNTHESIS
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_AVG_DIV || state_reg == ST_LVL_DIV))
        else $error("divider finished outside a divide state");

    a_channel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DONE) |=> (cur_ch_reg == $past(cur_ch_reg)))
        else $error("channel index moved without a result");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chan_we |-> (chan_wr_data.fill <= FILL_W'(WINDOW)))
        else $error("fill count beyond window");
`endif

endmodule

// ===== bench/msas_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msas_checker
// Watches the request, response and mux-order ports of the scaler. It keeps
// its own copy of the per-channel windows and calibration, predicts every
// result word, and compares each one in order with the response port.
// ----------------------------------------------------------------------------
module msas_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_ready,
    input  msas_pkg::req_word_t          req_word,
    input  logic                         rsp_valid,
    input  logic                         rsp_ready,
    input  msas_pkg::rsp_word_t          rsp_word,
    input  logic                         cfg_wr_en,
    input  logic [msas_pkg::ORDER_W-1:0] cfg_wr_data,
    output int                           mismatches,
    output int                           outstanding,
    output int                           compared
);
    import msas_pkg::*;

    logic [VAL_W-1:0]    history  [CHANNELS][WINDOW];
    logic [SUM_W-1:0]    run_sum  [CHANNELS];
    int unsigned         slot     [CHANNELS];
    int unsigned         filled   [CHANNELS];
    logic [VAL_W-1:0]    lo_bound [CHANNELS];
    logic [VAL_W-1:0]    hi_bound [CHANNELS];
    logic [CHANNELS-1:0] invert;
    int unsigned         cur_ch;
    logic [ORDER_W-1:0]  mux_order;
    rsp_word_t           due_words [$];
    rsp_word_t           due;

    function automatic void calibrate(input int unsigned ch,
                                      input logic [VAL_W-1:0] up,
                                      input logic [VAL_W-1:0] down);
        if (ch < CHANNELS)
        begin
            lo_bound[ch] = (up < down) ? up : down;
            hi_bound[ch] = (up > down) ? up : down;
            invert[ch]   = (up > down);
        end
    endfunction

    // Pushes one sample into the current channel's window and works out the word
    function automatic rsp_word_t average_and_scale(input logic [VAL_W-1:0] raw);
        int unsigned ch, avg, lo, hi, clamped, scaled, nxt;
        rsp_word_t   w;
        ch = cur_ch;
        run_sum[ch] = run_sum[ch] - history[ch][slot[ch]] + raw;
        history[ch][slot[ch]] = raw;
        slot[ch] = (slot[ch] + 1) % WINDOW;
        if (filled[ch] < WINDOW)
            filled[ch]++;
        avg = run_sum[ch] / filled[ch];

        lo = lo_bound[ch];
        hi = hi_bound[ch];
        clamped = avg;
        if (clamped < lo)
            clamped = lo;
        if (clamped > hi)
            clamped = hi;
        scaled = 0;
        if (hi > lo)
            scaled = (clamped - lo) * 255 / (hi - lo);

        nxt = (ch + 1) % CHANNELS;
        cur_ch = nxt;

        w.channel    = CHAN_W'(ch);
        w.averaged   = FIELD_W'(avg);
        w.level      = invert[ch] ? LEVEL_MAX - LEVEL_W'(scaled) : LEVEL_W'(scaled);
        w.mux_select = mux_order[CHAN_W*nxt +: CHAN_W];
        return w;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int k = 0; k < WINDOW; k++)
                    history[c][k] = '0;
                run_sum[c]  = '0;
                slot[c]     = 0;
                filled[c]   = 0;
                lo_bound[c] = '0;
                hi_bound[c] = '0;
            end
            invert      = '0;
            cur_ch      = 0;
            mux_order   = CHANNEL_ORDER_RESET;
            due_words.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
                mux_order = cfg_wr_data;

            if (rsp_valid && rsp_ready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("result word %p arrived with nothing expected", rsp_word);
                    mismatches++;
                end
                else
                begin
                    due = due_words.pop_front();
                    compare_field("channel", due.channel, rsp_word.channel);
                    compare_field("averaged", due.averaged, rsp_word.averaged);
                    compare_field("level", due.level, rsp_word.level);
                    compare_field("mux_select", due.mux_select, rsp_word.mux_select);
                    compared++;
                end
            end

            if (req_valid && req_ready)
            begin
                if (req_word.kind == KIND_CAL)
                    calibrate(req_word.cal_channel, req_word.cal_up, req_word.cal_down);
                else
                    due_words.push_back(average_and_scale(req_word.sample));
            end

            outstanding = due_words.size();
        end
    end

endmodule

// ===== bench/muxed_sensor_average_scaler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muxed_sensor_average_scaler_tb
// Drives sample and calibration words into the scaler, stalls both ports in
// random bursts, rewrites the mux-order register between phases, and leaves
// the prediction and comparison of every result word to the checker.
// ----------------------------------------------------------------------------
module muxed_sensor_average_scaler_tb;
    import msas_pkg::*;

    // Drain time after the last result, with margin for a trailing calibration
    localparam int DRAIN_CYCLES = 40;
    // Long enough for the block to back up and stall its request port
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_WORDS  = 320;
    localparam int PHASES       = 5;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_word_t           req_word;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_word_t           rsp_word;
    logic                cfg_wr_en;
    logic [ORDER_W-1:0]  cfg_wr_data;

    int mismatches, outstanding, compared;
    int sample_words, cal_words, order_writes;

    // Idling switches; the receiver owns hold_served, the main flow long_hold
    bit sender_idle_en;
    bit receiver_idle_en;
    bit long_hold;
    bit hold_served;

    logic [ORDER_W-1:0] orders [PHASES];

    muxed_sensor_average_scaler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_word    (req_word),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_word    (rsp_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    msas_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_word    (req_word),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_word    (rsp_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Response side: random stall bursts, plus one long hold-off on request
    always
    begin
        @(posedge clk);
        if (long_hold && !hold_served)
        begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_served = 1'b1;
        end
        else if (receiver_idle_en && $urandom_range(0, 3) == 0)
        begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(posedge clk);
        end
        else
            rsp_ready <= 1'b1;
    end

    // Half full-range readings, the rest the two extremes or a mid-range band
    function automatic logic [FIELD_W-1:0] pick_reading();
        case ($urandom_range(0, 9)) inside
            0:       return '0;
            1:       return '1;
            [2:4]:   return FIELD_W'($urandom_range(1800, 2300));
            default: return FIELD_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Fields a word kind ignores are still filled at random, for toggling
    function automatic req_word_t sample_word(input logic [FIELD_W-1:0] value);
        req_word_t w;
        w.kind        = KIND_SAMPLE;
        w.sample      = value;
        w.cal_channel = CHAN_W'($urandom_range(0, 15));
        w.cal_up      = FIELD_W'($urandom_range(0, 4095));
        w.cal_down    = FIELD_W'($urandom_range(0, 4095));
        return w;
    endfunction

    function automatic req_word_t cal_word(input logic [CHAN_W-1:0] ch,
                                           input logic [FIELD_W-1:0] up,
                                           input logic [FIELD_W-1:0] down);
        req_word_t w;
        w.kind        = KIND_CAL;
        w.sample      = FIELD_W'($urandom_range(0, 4095));
        w.cal_channel = ch;
        w.cal_up      = up;
        w.cal_down    = down;
        return w;
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    // Valid stays high into the next word unless a gap is drawn.
    task automatic send_word(input req_word_t w);
        if (sender_idle_en && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (w.kind == KIND_CAL)
            cal_words++;
        else
            sample_words++;
    endtask

    // Stop offering, let every result out, then give any calibration time to finish
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(input logic [ORDER_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        order_writes++;
    endtask

    // Roughly one calibration in seven; one in eight of those with equal readings
    task automatic random_words(input int count);
        logic [FIELD_W-1:0] up, down;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                up   = pick_reading();
                down = ($urandom_range(0, 7) == 0) ? up : pick_reading();
                send_word(cal_word(CHAN_W'($urandom_range(0, CHANNELS - 1)), up, down));
            end
            else
                send_word(sample_word(pick_reading()));
        end
    endtask

    // Channel index starts at 0 and steps by one per sample word
    task automatic directed_words();
        send_word(sample_word(12'hFFF));                // ch0, never calibrated: zero range
        send_word(cal_word(4'd1, 12'hFFF, 12'h000));    // full range, inverted
        send_word(cal_word(4'd2, 12'h000, 12'hFFF));    // full range, upright
        send_word(cal_word(4'd3, 12'd2048, 12'd2048));  // equal readings
        send_word(cal_word(4'd4, 12'd3000, 12'd1000));  // inverted, clamp test
        send_word(cal_word(4'd15, 12'hFFF, 12'hFFF));   // top channel, equal at max
        send_word(sample_word(12'h000));                // ch1 -> 255 after inversion
        send_word(sample_word(12'hFFF));                // ch2 -> 255
        send_word(sample_word(12'd2048));               // ch3, degenerate
        send_word(sample_word(12'd500));                // ch4, raised to low bound
        send_word(cal_word(4'd4, 12'd1000, 12'd3000));  // invert bit cleared again
        for (int c = 5; c < CHANNELS; c++)
            send_word(sample_word((c % 2) ? 12'hFFF : 12'h000));
        send_word(sample_word(12'h000));                // ch0 again, window of two
        send_word(sample_word(12'hFFF));                // ch1
        send_word(sample_word(12'd1));                  // ch2
        send_word(sample_word(12'd2048));               // ch3
        send_word(sample_word(12'd3500));               // ch4, average 2000 within the bounds
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_valid        = 1'b0;
        req_word         = '0;
        rsp_ready        = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
        long_hold        = 1'b0;
        hold_served      = 1'b0;

        // Extremes first, then a random order, a fixed pattern and another random one
        orders[0] = '0;
        orders[1] = '1;
        orders[2] = {$urandom, $urandom};
        orders[3] = 64'h0123_4567_89AB_CDEF;
        orders[4] = {$urandom, $urandom};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset mux order, then a full drain
        directed_words();
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_order(orders[p]);
            if (p == 1)
            begin
                // Sender keeps offering while the receiver holds off
                sender_idle_en = 1'b0;
                long_hold      = 1'b1;
                random_words(60);
                sender_idle_en = 1'b1;
            end
            if (p == PHASES - 1)
            begin
                // Closing phase runs flat out on both sides
                sender_idle_en   = 1'b0;
                receiver_idle_en = 1'b0;
            end
            random_words(PHASE_WORDS);
            settle();
        end

        $display("Sent %0d sample and %0d calibration words over %0d mux orders",
                 sample_words, cal_words, order_writes + 1);
        $display("Compared %0d result words, %0d field mismatches", compared, mismatches);
        if (outstanding != 0)
            $error("%0d result words never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
